// ----- rtl/core/mma_pkg.sv -----
// shared types and constants of the multichannel moving-average filter
`default_nettype none

package mma_pkg;

  // fixed field geometry of the item formats
  localparam int SAMPLE_BITS = 16;
  localparam int LANES       = 4;
  localparam int WIN_W       = 7;
  localparam int CHAN_W      = 3;
  localparam int CFG_DATA_W  = 7;
  localparam int CNT_W       = $clog2(SAMPLE_BITS);

  // register values after reset
  localparam logic [WIN_W-1:0]  WIN_RESET  = WIN_W'(8);
  localparam logic [CHAN_W-1:0] CHAN_RESET = CHAN_W'(4);

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_WINDOW_LENGTH   = 1'b0,
    REG_ACTIVE_CHANNELS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_0;
    logic signed [SAMPLE_BITS-1:0] sample_1;
    logic signed [SAMPLE_BITS-1:0] sample_2;
    logic signed [SAMPLE_BITS-1:0] sample_3;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mean_0;
    logic signed [SAMPLE_BITS-1:0] mean_1;
    logic signed [SAMPLE_BITS-1:0] mean_2;
    logic signed [SAMPLE_BITS-1:0] mean_3;
    logic        [WIN_W-1:0]       samples_averaged;
  } out_item_t;

  // controls from the sequencer to the serial dividers
  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/multichannel_moving_average_top.sv -----
// top level of the multichannel moving-average (boxcar) filter
// each item passes the update, load, bit-serial divide and done states before its result is valid
// the input takes a new item only once the last result has left the bit-serial dividers (one quotient bit a cycle)
// the output register frees the input side while a result waits for its transfer
// reset (synchronous, active low) sets window 8, four channels, empty history
// any configuration write empties the history too; ring contents are never cleared
`default_nettype none

module multichannel_moving_average_top #(
  parameter int MAX_WINDOW = 64,
  parameter int CHANNELS   = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire mma_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output mma_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire mma_pkg::cfg_reg_t                 cfg_index,
  input  wire logic [mma_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import mma_pkg::*;

  // the window register is 7 bits wide, so the ring never needs more slots than that allows
  localparam int RING_DEPTH = (MAX_WINDOW > (2**WIN_W - 1)) ? (2**WIN_W - 1) : MAX_WINDOW;
  localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W      = SAMPLE_BITS + $clog2(RING_DEPTH + 1) + 1;
  localparam int RAM_W      = CHANNELS * SAMPLE_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_LOAD,
    S_DIV,
    S_DONE
  } state_t;

  // control and configuration state
  state_t                  state_r, state_nxt;
  logic [WIN_W-1:0]        window_r, window_nxt;
  logic [CHAN_W-1:0]       chans_r, chans_nxt;
  logic [WIN_W-1:0]        fill_r, fill_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic [CNT_W-1:0]        bit_cnt_r, bit_cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0] sum_r [CHANNELS];
  logic signed [SUM_W-1:0] sum_nxt [CHANNELS];

  // payload
  logic signed [SAMPLE_BITS-1:0] smp_r [CHANNELS];
  out_item_t                     out_data_r;

  logic [WIN_W-1:0]              win_eff;
  logic [CHAN_W-1:0]             chan_eff;
  logic                          in_xfer;
  logic                          out_load;
  logic                          ram_we;
  logic [RAM_W-1:0]              ram_wdata;
  logic [RAM_W-1:0]              ram_rdata;
  logic [WIN_W-1:0]              slot_inc;
  div_ctl_t                      div_ctl;
  logic signed [SAMPLE_BITS-1:0] smp_in [LANES];
  logic signed [SAMPLE_BITS-1:0] quo_w [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] mean_w [LANES];

  // out-of-range register values fold onto the nearest legal one
  always_comb begin
    if (window_r == '0) begin
      win_eff = WIN_W'(1);
    end else if (window_r > WIN_W'(RING_DEPTH)) begin
      win_eff = WIN_W'(RING_DEPTH);
    end else begin
      win_eff = window_r;
    end
    if (chans_r == '0) begin
      chan_eff = CHAN_W'(1);
    end else if (chans_r > CHAN_W'(CHANNELS)) begin
      chan_eff = CHAN_W'(CHANNELS);
    end else begin
      chan_eff = chans_r;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign slot_inc = WIN_W'(slot_r) + WIN_W'(1);

  assign smp_in[0] = in_data.sample_0;
  assign smp_in[1] = in_data.sample_1;
  assign smp_in[2] = in_data.sample_2;
  assign smp_in[3] = in_data.sample_3;

  // history ring: read the slot to be overwritten at the input transfer,
  // write the new vector into it in the following cycle
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      ram_wdata[c*SAMPLE_BITS +: SAMPLE_BITS] = smp_r[c];
    end
  end

  mma_ram #(
    .WIDTH (RAM_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (ram_wdata),
    .re    (in_xfer),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  // one serial divider per channel, all stepped together
  for (genvar g = 0; g < CHANNELS; g++) begin : g_div
    mma_div #(
      .SUM_W (SUM_W)
    ) u_div (
      .clk      (clk),
      .ctl      (div_ctl),
      .dividend (sum_r[g]),
      .divisor  (fill_r),
      .quotient (quo_w[g])
    );
  end

  // lanes beyond the build or the active count read as zero
  for (genvar g = 0; g < LANES; g++) begin : g_mean
    if (g < CHANNELS) begin : g_live
      assign mean_w[g] = (CHAN_W'(g) < chan_eff) ? quo_w[g] : '0;
    end else begin : g_absent
      assign mean_w[g] = '0;
    end
  end

  // sequencer next state
  always_comb begin
    logic signed [SAMPLE_BITS-1:0] old_v;
    logic                          full;

    state_nxt     = state_r;
    window_nxt    = window_r;
    chans_nxt     = chans_r;
    fill_nxt      = fill_r;
    slot_nxt      = slot_r;
    bit_cnt_nxt   = bit_cnt_r;
    out_valid_nxt = out_valid_r;
    sum_nxt       = sum_r;
    div_ctl       = '0;
    ram_we        = 1'b0;
    out_load      = 1'b0;
    full          = (fill_r >= win_eff);
    old_v         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        // running sums drop the oldest sample once the window is full
        for (int c = 0; c < CHANNELS; c++) begin
          old_v      = full ? signed'(ram_rdata[c*SAMPLE_BITS +: SAMPLE_BITS]) : '0;
          sum_nxt[c] = sum_r[c] - SUM_W'(old_v) + SUM_W'(smp_r[c]);
        end
        ram_we   = 1'b1;
        slot_nxt = (slot_inc >= win_eff) ? '0 : SLOT_W'(slot_inc);
        if (!full) begin
          fill_nxt = fill_r + WIN_W'(1);
        end
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        div_ctl.load = 1'b1;
        bit_cnt_nxt  = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        div_ctl.step = 1'b1;
        if (bit_cnt_r == CNT_W'(SAMPLE_BITS - 1)) begin
          bit_cnt_nxt = '0;
          state_nxt   = S_DONE;
        end else begin
          bit_cnt_nxt = bit_cnt_r + CNT_W'(1);
        end
      end
      S_DONE: begin
        // wait here only while an older result still occupies the output register
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end

    // the user must make register writes only while idle (the block does not enforce it); each one empties the history
    if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH:   window_nxt = cfg_wdata[WIN_W-1:0];
        REG_ACTIVE_CHANNELS: chans_nxt  = cfg_wdata[CHAN_W-1:0];
        default:             window_nxt = window_r;
      endcase
      for (int c = 0; c < CHANNELS; c++) begin
        sum_nxt[c] = '0;
      end
      fill_nxt = '0;
      slot_nxt = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      window_r    <= WIN_RESET;
      chans_r     <= CHAN_RESET;
      fill_r      <= '0;
      slot_r      <= '0;
      bit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        sum_r[c] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      window_r    <= window_nxt;
      chans_r     <= chans_nxt;
      fill_r      <= fill_nxt;
      slot_r      <= slot_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
    end
  end

  // payload registers: inactive lanes are stored as zero
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int c = 0; c < CHANNELS; c++) begin
        smp_r[c] <= (CHAN_W'(c) < chan_eff) ? smp_in[c] : '0;
      end
    end
    if (out_load) begin
      out_data_r.mean_0           <= mean_w[0];
      out_data_r.mean_1           <= mean_w[1];
      out_data_r.mean_2           <= mean_w[2];
      out_data_r.mean_3           <= mean_w[3];
      out_data_r.samples_averaged <= fill_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // the fill count never runs past the window
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= win_eff)
    else $error("fill count exceeds window");

  // the write slot always stays inside the window
  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    WIN_W'(slot_r) < win_eff)
    else $error("write slot outside window");

  // a result never carries a zero divisor
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.samples_averaged != '0))
    else $error("result with zero divisor");

  // a new result appears only after the divider has finished
  a_result_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside completion");

  // the bit counter rests at zero outside the divide phase
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_DIV) |-> (bit_cnt_r == '0))
    else $error("bit counter running outside divide");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/mma_ram.sv -----
// generic single-write, single-read RAM with registered read data
`default_nettype none

module mma_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic                                        re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mma_div.sv -----
// bit-serial restoring divider, signed sum by unsigned count, truncating toward zero
`default_nettype none

module mma_div #(
  parameter int SUM_W = 23
) (
  input  wire logic                             clk,
  input  wire mma_pkg::div_ctl_t                ctl,
  input  wire logic signed [SUM_W-1:0]          dividend,
  input  wire logic [mma_pkg::WIN_W-1:0]        divisor,
  output logic signed [mma_pkg::SAMPLE_BITS-1:0] quotient
);

  import mma_pkg::*;

  logic                   neg_r;
  logic [WIN_W-1:0]       rem_r;
  logic [SAMPLE_BITS-1:0] shreg_r;

  logic [SUM_W-1:0] mag;
  logic [WIN_W:0]   trial;
  logic             fits;

  // quotient magnitude fits in SAMPLE_BITS, so the top bits seed the remainder
  assign mag   = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
  assign trial = {rem_r, shreg_r[SAMPLE_BITS-1]};
  assign fits  = (trial >= (WIN_W+1)'(divisor));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      neg_r   <= dividend[SUM_W-1];
      rem_r   <= WIN_W'(mag[SUM_W-1:SAMPLE_BITS]);
      shreg_r <= mag[SAMPLE_BITS-1:0];
    end else if (ctl.step) begin
      rem_r   <= fits ? WIN_W'(trial - (WIN_W+1)'(divisor)) : WIN_W'(trial);
      shreg_r <= {shreg_r[SAMPLE_BITS-2:0], fits};
    end
  end

  assign quotient = neg_r ? -signed'(shreg_r) : signed'(shreg_r);

endmodule

`default_nettype wire
